FILE: hdl/dew_point_magnus_unit_defines.svh
// assertion macros shared by the dew point unit
`ifndef DEW_POINT_MAGNUS_UNIT_DEFINES_SVH
`define DEW_POINT_MAGNUS_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define DPM_ASSERT_NEVER(label, cond, msg) \
	`DPM_ASSERT_IMP(label, 1'b1, !(cond), msg)

`endif

FILE: hdl/dpm_pkg.sv
// shared types and constants of the dew point unit
package dpm_pkg;

	localparam int T_W = 11;
	localparam int H_W = 10;
	localparam int DEW_W = 11;
	localparam int E_W = 4;
	localparam int LN_TERMS = 10;
	localparam int RH_FULL = 1000;
	localparam int DEW_MIN = -1000;
	localparam int DEW_MAX = 800;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_READ_FAIL = 2'd1,
		ST_UNDEFINED = 2'd2
	} status_t;

endpackage

FILE: hdl/dpm_in_if.sv
// reading channel: temperature, humidity and read flag
interface dpm_in_if import dpm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [T_W-1:0] temperature;
	logic [H_W-1:0]        humidity;
	logic                  read_valid;

	modport source (output valid, temperature, humidity, read_valid, input ready);
	modport sink (input valid, temperature, humidity, read_valid, output ready);
endinterface

FILE: hdl/dpm_out_if.sv
// result channel: dew point and status
interface dpm_out_if import dpm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DEW_W-1:0] dew_point;
	status_t                 status;

	modport source (output valid, dew_point, status, input ready);
	modport sink (input valid, dew_point, status, output ready);
endinterface

FILE: hdl/dpm_div_cell.sv
// one restoring division step with its pipeline register
module dpm_div_cell import dpm_pkg::*; #(
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] nq_i,
	input  logic [DW-1:0] den_i,
	input  logic [SW-1:0] side_i,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] nq_o,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_n;
	logic [QW-1:0] nq_n;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] nq_q;
	logic [DW-1:0] den_q;
	logic [SW-1:0] side_q;

	always_comb begin
		trial = {rem_i, nq_i[QW-1]};
		diff = trial - {1'b0, den_i};
		ge = trial >= {1'b0, den_i};
		rem_n = ge ? diff[DW-1:0] : trial[DW-1:0];
		// numerator bits shift out the top, quotient bits shift in below
		nq_n = QW'({nq_i, ge});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			nq_q <= '0;
			den_q <= '0;
			side_q <= '0;
		end else if (en) begin
			rem_q <= rem_n;
			nq_q <= nq_n;
			den_q <= den_i;
			side_q <= side_i;
		end
	end

	assign rem_o = rem_q;
	assign nq_o = nq_q;
	assign den_o = den_q;
	assign side_o = side_q;

endmodule

FILE: hdl/dpm_divider.sv
// pipelined unsigned divider, one cell per quotient bit
module dpm_divider import dpm_pkg::*; #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_o
);

	logic [DW-1:0] rem_c  [0:QW-1];
	logic [DW-1:0] den_c  [0:QW-1];
	logic [QW-1:0] nq_c   [0:QW];
	logic [SW-1:0] side_c [0:QW];

	// upper numerator bits are below the divisor since the quotient fits QW bits
	assign rem_c[0] = DW'(num >> QW);
	assign nq_c[0] = num[QW-1:0];
	assign den_c[0] = den;
	assign side_c[0] = side_i;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		if (i < QW - 1) begin : g_mid
			dpm_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.rem_i(rem_c[i]), .nq_i(nq_c[i]), .den_i(den_c[i]), .side_i(side_c[i]),
				.rem_o(rem_c[i+1]), .nq_o(nq_c[i+1]), .den_o(den_c[i+1]),
				.side_o(side_c[i+1])
			);
		end else begin : g_last
			dpm_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.rem_i(rem_c[i]), .nq_i(nq_c[i]), .den_i(den_c[i]), .side_i(side_c[i]),
				.rem_o(), .nq_o(nq_c[i+1]), .den_o(), .side_o(side_c[i+1])
			);
		end
	end

	assign quo = nq_c[QW];
	assign side_o = side_c[QW];

endmodule

FILE: hdl/dpm_term_cell.sv
// one odd-power term of the log series: next power, divide by 2k+1, accumulate
module dpm_term_cell import dpm_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SW = 1,
	parameter int K_IDX = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] z2_i,
	input  logic [FRAC_BITS-1:0] p_i,
	input  logic [FRAC_BITS-1:0] s_i,
	input  logic [E_W-1:0]       e_i,
	input  logic [SW-1:0]        side_i,
	output logic [FRAC_BITS-1:0] z2_o,
	output logic [FRAC_BITS-1:0] p_o,
	output logic [FRAC_BITS-1:0] s_o,
	output logic [E_W-1:0]       e_o,
	output logic [SW-1:0]        side_o
);

	localparam int F = FRAC_BITS;
	localparam int DIVR = 2 * K_IDX + 1;
	localparam logic [F-1:0] RECIP = F'((64'd1 << F) / 64'(DIVR));
	localparam logic [2*F-1:0] HALF = (2*F)'(1) << (F - 1);

	logic [2*F-1:0] prod_s1;
	logic [F-1:0]   z2_s1, s_s1;
	logic [E_W-1:0] e_s1;
	logic [SW-1:0]  side_s1;

	logic [F-1:0]   pk, xk;
	logic [F-1:0]   pk_s2, x_s2, z2_s2, s_s2;
	logic [2*F-1:0] xm_s2;
	logic [E_W-1:0] e_s2;
	logic [SW-1:0]  side_s2;

	logic [F-1:0]   q0, rr, qk;
	logic [F-1:0]   p_s3, z2_s3, s_s3;
	logic [E_W-1:0] e_s3;
	logic [SW-1:0]  side_s3;

	always_comb begin
		pk = F'((prod_s1 + HALF) >> F);
		// adding k gives rounding to nearest for the divide by 2k+1
		xk = pk + F'(K_IDX);
		// reciprocal estimate is low by at most one
		q0 = F'(xm_s2 >> F);
		rr = x_s2 - F'(q0) * F'(DIVR);
		qk = q0 + F'(rr >= F'(DIVR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
			z2_s1 <= '0;
			s_s1 <= '0;
			e_s1 <= '0;
			side_s1 <= '0;
			pk_s2 <= '0;
			x_s2 <= '0;
			xm_s2 <= '0;
			z2_s2 <= '0;
			s_s2 <= '0;
			e_s2 <= '0;
			side_s2 <= '0;
			p_s3 <= '0;
			z2_s3 <= '0;
			s_s3 <= '0;
			e_s3 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			prod_s1 <= (2*F)'(p_i) * (2*F)'(z2_i);
			z2_s1 <= z2_i;
			s_s1 <= s_i;
			e_s1 <= e_i;
			side_s1 <= side_i;
			pk_s2 <= pk;
			x_s2 <= xk;
			xm_s2 <= (2*F)'(xk) * (2*F)'(RECIP);
			z2_s2 <= z2_s1;
			s_s2 <= s_s1;
			e_s2 <= e_s1;
			side_s2 <= side_s1;
			p_s3 <= pk_s2;
			z2_s3 <= z2_s2;
			s_s3 <= s_s2 + qk;
			e_s3 <= e_s2;
			side_s3 <= side_s2;
		end
	end

	assign z2_o = z2_s3;
	assign p_o = p_s3;
	assign s_o = s_s3;
	assign e_o = e_s3;
	assign side_o = side_s3;

endmodule

FILE: hdl/dpm_ln.sv
// pipelined natural log of a 10-bit integer by the atanh series
module dpm_ln import dpm_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [H_W-1:0]         x,
	input  logic [SW-1:0]          side_i,
	output logic [FRAC_BITS+3:0]   ln_o,
	output logic [SW-1:0]          side_o
);

	localparam int F = FRAC_BITS;
	localparam int L_W = F + 4;
	localparam int NZ_W = 2 * F + 1;
	localparam logic [F-1:0] LN2 =
		F'((LN2_Q32 + (64'd1 << (31 - F))) >> (32 - F));
	localparam logic [F+1:0] ONE = (F+2)'(1) << F;
	localparam logic [2*F-1:0] HALF = (2*F)'(1) << (F - 1);

	logic [E_W-1:0]  e;
	logic [F+H_W-1:0] wide;
	logic [F:0]      mq;
	logic [F+1:0]    dz;
	logic [NZ_W-1:0] nz;

	logic [F-1:0]      z;
	logic [SW+E_W-1:0] zside;

	logic [2*F-1:0] zz_s1;
	logic [F-1:0]   z_s1;
	logic [E_W-1:0] e_s1;
	logic [SW-1:0]  side_s1;

	logic [F-1:0]   z2_c   [0:LN_TERMS-1];
	logic [F-1:0]   p_c    [0:LN_TERMS-1];
	logic [F-1:0]   s_c    [0:LN_TERMS];
	logic [E_W-1:0] e_c    [0:LN_TERMS];
	logic [SW-1:0]  side_c [0:LN_TERMS];

	logic [L_W-1:0] ln_q;
	logic [SW-1:0]  side_q;

	always_comb begin
		e = '0;
		for (int i = 1; i < H_W; i++) begin
			if (x[i]) begin
				e = E_W'(i);
			end
		end
		wide = {x, {F{1'b0}}};
		// mantissa in [1,2) with F fraction bits
		mq = (F+1)'(wide >> e);
		dz = (F+2)'(mq) + ONE;
		nz = {1'b0, mq[F-1:0], {F{1'b0}}} + NZ_W'(dz >> 1);
	end

	dpm_divider #(.NW(NZ_W), .DW(F + 2), .QW(F), .SW(SW + E_W)) u_zdiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(nz), .den(dz), .side_i({e, side_i}),
		.quo(z), .side_o(zside)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zz_s1 <= '0;
			z_s1 <= '0;
			e_s1 <= '0;
			side_s1 <= '0;
			z2_c[0] <= '0;
			p_c[0] <= '0;
			s_c[0] <= '0;
			e_c[0] <= '0;
			side_c[0] <= '0;
		end else if (en) begin
			zz_s1 <= (2*F)'(z) * (2*F)'(z);
			z_s1 <= z;
			e_s1 <= zside[SW+E_W-1 -: E_W];
			side_s1 <= zside[SW-1:0];
			z2_c[0] <= F'((zz_s1 + HALF) >> F);
			p_c[0] <= z_s1;
			s_c[0] <= z_s1;
			e_c[0] <= e_s1;
			side_c[0] <= side_s1;
		end
	end

	for (genvar k = 0; k < LN_TERMS; k++) begin : g_term
		if (k < LN_TERMS - 1) begin : g_mid
			dpm_term_cell #(.FRAC_BITS(F), .SW(SW), .K_IDX(k + 1)) u_term (
				.clk(clk), .arst_n(arst_n), .en(en),
				.z2_i(z2_c[k]), .p_i(p_c[k]), .s_i(s_c[k]), .e_i(e_c[k]),
				.side_i(side_c[k]),
				.z2_o(z2_c[k+1]), .p_o(p_c[k+1]), .s_o(s_c[k+1]), .e_o(e_c[k+1]),
				.side_o(side_c[k+1])
			);
		end else begin : g_last
			dpm_term_cell #(.FRAC_BITS(F), .SW(SW), .K_IDX(k + 1)) u_term (
				.clk(clk), .arst_n(arst_n), .en(en),
				.z2_i(z2_c[k]), .p_i(p_c[k]), .s_i(s_c[k]), .e_i(e_c[k]),
				.side_i(side_c[k]),
				.z2_o(), .p_o(), .s_o(s_c[k+1]), .e_o(e_c[k+1]),
				.side_o(side_c[k+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_q <= '0;
			side_q <= '0;
		end else if (en) begin
			ln_q <= L_W'(e_c[LN_TERMS]) * L_W'(LN2) + L_W'({s_c[LN_TERMS], 1'b0});
			side_q <= side_c[LN_TERMS];
		end
	end

	assign ln_o = ln_q;
	assign side_o = side_q;

endmodule

FILE: hdl/dew_point_magnus_unit.sv
// dew point unit top level: Magnus-Tetens dew point in fixed point
//
// channel   dir  payload
// reading   in   temperature[10:0] signed, humidity[9:0], read_valid
// result    out  dew_point[10:0] signed, status[1:0]
//
// one reading per clock sustained while results are taken; the pipeline holds
// divider rows of FRAC_BITS+4, FRAC_BITS and 12 cells and 30 log series stages.
// reset clears every pipeline register, no result is pending afterwards.
// the whole pipeline advances together; it holds while a result waits unaccepted.
`include "dew_point_magnus_unit_defines.svh"

module dew_point_magnus_unit import dpm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	dpm_in_if.sink    reading,
	dpm_out_if.source result
);

	localparam int F = FRAC_BITS;
	localparam int AD_W = 19;
	localparam int AQ_W = F + 4;
	localparam int AN_W = F + 22;
	localparam int A_W = F + 5;
	localparam int L_W = F + 4;
	localparam int G_W = F + 6;
	localparam int DN_W = F + 20;
	localparam int DD_W = F + 9;
	localparam int DQ_W = 12;
	localparam int SA_W = 1 + 2 + 1 + H_W;
	localparam int LH_W = 2 + A_W;
	localparam int SD_W = 1 + 2 + 1;
	localparam logic [63:0] K_FIX = ((64'd1762 << F) + 64'd50) / 64'd100;

	logic en;

	logic signed [T_W-1:0] t;
	logic [T_W-1:0]        t_abs;
	logic signed [19:0]    a_den_full;
	logic [AD_W-1:0]       a_den;
	logic [20:0]           a_prod;
	logic [AN_W-1:0]       a_num;
	status_t               st_in;

	logic [AQ_W-1:0]       aq;
	logic [SA_W-1:0]       aside;
	logic [A_W-1:0]        a_mag;
	logic signed [A_W-1:0] a_val;
	status_t               a_status;

	logic [L_W-1:0]        ln_h, ln_c;
	logic [LH_W-1:0]       lh_side;
	logic                  lc_valid;

	logic signed [L_W:0]   lr;
	logic signed [G_W-1:0] g;
	logic [G_W-2:0]        g_abs;
	logic signed [G_W:0]   kmg;
	logic [DD_W-1:0]       dd;

	logic [DN_W-1:0] gm_s1;
	logic [DD_W-1:0] dd_s1;
	logic            neg_s1;
	status_t         st_s1;
	logic            v_s1;

	logic [DN_W-1:0]       d_num;
	logic [DQ_W-1:0]       dq;
	logic [SD_W-1:0]       dside;
	logic signed [DQ_W:0]  dw;
	logic [DEW_W-1:0]      dew_n;
	status_t               d_status;

	logic             valid_q;
	logic [DEW_W-1:0] dew_q;
	status_t          status_q;

	// pipeline moves unless the result register holds an untaken result
	assign en = !valid_q || result.ready;
	assign reading.ready = en;

	always_comb begin
		t = reading.temperature;
		t_abs = t[T_W-1] ? T_W'(-t) : T_W'(t);
		a_den_full = 20'sd243120 + 20'(t) * 20'sd100;
		a_den = a_den_full[AD_W-1:0];
		a_prod = 21'(t_abs) * 21'd1762;
		a_num = (AN_W'(a_prod) << F) + AN_W'(a_den >> 1);
		if (!reading.read_valid) begin
			st_in = ST_READ_FAIL;
		end else if (reading.humidity == '0) begin
			st_in = ST_UNDEFINED;
		end else begin
			st_in = ST_OK;
		end
	end

	// 17.62*T/(243.12+T)
	dpm_divider #(.NW(AN_W), .DW(AD_W), .QW(AQ_W), .SW(SA_W)) u_adiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(a_num), .den(a_den),
		.side_i({reading.valid, st_in, t[T_W-1], reading.humidity}),
		.quo(aq), .side_o(aside)
	);

	always_comb begin
		a_mag = A_W'(aq);
		a_val = aside[H_W] ? -$signed(a_mag) : $signed(a_mag);
		a_status = status_t'(aside[SA_W-2 -: 2]);
	end

	dpm_ln #(.FRAC_BITS(F), .SW(LH_W)) u_ln_rh (
		.clk(clk), .arst_n(arst_n), .en(en),
		.x(aside[H_W-1:0]), .side_i({a_status, a_val}),
		.ln_o(ln_h), .side_o(lh_side)
	);

	// same pipeline on full scale humidity, carries the transfer valid bit
	dpm_ln #(.FRAC_BITS(F), .SW(1)) u_ln_full (
		.clk(clk), .arst_n(arst_n), .en(en),
		.x(H_W'(RH_FULL)), .side_i(aside[SA_W-1]),
		.ln_o(ln_c), .side_o(lc_valid)
	);

	always_comb begin
		lr = $signed({1'b0, ln_h}) - $signed({1'b0, ln_c});
		g = G_W'(lr) + G_W'($signed(lh_side[A_W-1:0]));
		g_abs = g[G_W-1] ? (G_W-1)'(-g) : (G_W-1)'(g);
		kmg = $signed((G_W+1)'(K_FIX)) - (G_W+1)'(g);
		dd = DD_W'($unsigned(kmg)) * DD_W'(10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm_s1 <= '0;
			dd_s1 <= '0;
			neg_s1 <= 1'b0;
			st_s1 <= ST_OK;
			v_s1 <= 1'b0;
		end else if (en) begin
			gm_s1 <= DN_W'(g_abs) * DN_W'(24312);
			dd_s1 <= dd;
			neg_s1 <= g[G_W-1];
			st_s1 <= status_t'(lh_side[LH_W-1 -: 2]);
			v_s1 <= lc_valid;
		end
	end

	assign d_num = gm_s1 + DN_W'(dd_s1 >> 1);

	// 243.12*g/(17.62-g) in tenths
	dpm_divider #(.NW(DN_W), .DW(DD_W), .QW(DQ_W), .SW(SD_W)) u_ddiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(d_num), .den(dd_s1), .side_i({v_s1, st_s1, neg_s1}),
		.quo(dq), .side_o(dside)
	);

	always_comb begin
		dw = dside[0] ? -$signed((DQ_W+1)'(dq)) : $signed((DQ_W+1)'(dq));
		d_status = status_t'(dside[2:1]);
		if (d_status != ST_OK) begin
			dew_n = '0;
		end else if (dw < DEW_MIN) begin
			dew_n = DEW_W'(DEW_MIN);
		end else if (dw > DEW_MAX) begin
			dew_n = DEW_W'(DEW_MAX);
		end else begin
			dew_n = DEW_W'(dw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dew_q <= '0;
			status_q <= ST_OK;
		end else if (en) begin
			valid_q <= dside[SD_W-1];
			dew_q <= dew_n;
			status_q <= d_status;
		end
	end

	assign result.valid = valid_q;
	assign result.dew_point = $signed(dew_q);
	assign result.status = status_q;

	`DPM_ASSERT_IMP(a_fault_zero, result.valid && (result.status != ST_OK), result.dew_point == '0, "dew point not zero on fault status")
	`DPM_ASSERT_IMP(a_sat_range, result.valid && (result.status == ST_OK), (result.dew_point >= DEW_W'(DEW_MIN)) && (result.dew_point <= DEW_W'(DEW_MAX)), "dew point outside saturation range")
	`DPM_ASSERT_NEVER(a_stall_holds_input, result.valid && !result.ready && reading.ready, "reading transfer while result stalled")

endmodule

FILE: tb/tb_dew_point_magnus_unit.sv
// testbench of the dew point unit: directed table and random readings checked against a predictor
module tb_dew_point_magnus_unit import dpm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam int LATENCY = 2 * FRAC_BITS + 51;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 2000;

	typedef struct {
		logic signed [T_W-1:0] temperature;
		logic [H_W-1:0]        humidity;
		logic                  read_valid;
		bit                    known;
		logic signed [DEW_W-1:0] dew_point;
		status_t               status;
	} reading_row_t;

	typedef struct {
		logic signed [DEW_W-1:0] dew_point;
		status_t                 status;
	} dew_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   err_count = 0;
	int   idle_cycles = 0;
	bit   stim_done = 1'b0;
	dew_result_t expected_q[$];

	dpm_in_if  reading ();
	dpm_out_if result ();

	dew_point_magnus_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.reading(reading.sink),
		.result(result.source)
	);

	always #4 clk = ~clk;

	function automatic longint round_div(longint n, longint d);
		longint mag;
		if (n < 0) begin
			mag = (-n + d / 2) / d;
			return -mag;
		end
		return (n + d / 2) / d;
	endfunction

	// series log of an integer 1..1023 in q.FRAC_BITS
	function automatic longint fixed_ln(longint x);
		longint one, ln2, mq, z, z2, p, s;
		int e;
		one = longint'(1) << FRAC_BITS;
		ln2 = longint'((LN2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
		e = 0;
		while (e < 10 && (x >> (e + 1)) != 0)
			e++;
		mq = (x << FRAC_BITS) >> e;
		z = round_div((mq - one) * one, mq + one);
		z2 = round_div(z * z, one);
		p = z;
		s = z;
		for (int k = 1; k <= LN_TERMS; k++) begin
			p = round_div(p * z2, one);
			s += round_div(p, 2 * k + 1);
		end
		return e * ln2 + 2 * s;
	endfunction

	function automatic dew_result_t dew_point_of(logic signed [T_W-1:0] temp,
			logic [H_W-1:0] hum, logic ok);
		dew_result_t r;
		longint one, t, a, g, kq, dw;
		one = longint'(1) << FRAC_BITS;
		r.dew_point = '0;
		if (!ok) begin
			r.status = ST_READ_FAIL;
			return r;
		end
		if (hum == 0) begin
			r.status = ST_UNDEFINED;
			return r;
		end
		t = temp;
		a = round_div(1762 * t * one, 243120 + 100 * t);
		g = fixed_ln(hum) - fixed_ln(RH_FULL) + a;
		kq = round_div(1762 * one, 100);
		dw = round_div(24312 * g, 10 * (kq - g));
		if (dw < DEW_MIN)
			dw = DEW_MIN;
		if (dw > DEW_MAX)
			dw = DEW_MAX;
		r.dew_point = dw[DEW_W-1:0];
		r.status = ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	task automatic send_reading(reading_row_t row);
		dew_result_t exp_r;
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
			reading.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		reading.valid <= 1'b1;
		reading.temperature <= row.temperature;
		reading.humidity <= row.humidity;
		reading.read_valid <= row.read_valid;
		exp_r = dew_point_of(row.temperature, row.humidity, row.read_valid);
		if (row.known && (exp_r.dew_point !== row.dew_point || exp_r.status !== row.status))
			report_mismatch("predictor disagrees with table row");
		if (row.known) begin
			exp_r.dew_point = row.dew_point;
			exp_r.status = row.status;
		end
		@(posedge clk);
		while (!reading.ready)
			@(posedge clk);
		expected_q.push_back(exp_r);
		@(negedge clk);
	endtask

	function automatic reading_row_t mk_row(int temp, int hum, bit ok, bit known = 0,
			int dew = 0, status_t st = ST_OK);
		reading_row_t r;
		r.temperature = temp[T_W-1:0];
		r.humidity = hum[H_W-1:0];
		r.read_valid = ok;
		r.known = known;
		r.dew_point = dew[DEW_W-1:0];
		r.status = st;
		return r;
	endfunction

	// stimulus
	initial begin
		reading_row_t table_rows[$];
		reading_row_t row;
		reading.valid = 1'b0;
		reading.temperature = '0;
		reading.humidity = '0;
		reading.read_valid = 1'b0;
		table_rows = '{
			mk_row(250, 500, 0, 1, 0, ST_READ_FAIL),
			mk_row(250, 0, 0, 1, 0, ST_READ_FAIL),
			mk_row(250, 0, 1, 1, 0, ST_UNDEFINED),
			mk_row(-1024, 0, 1, 1, 0, ST_UNDEFINED),
			mk_row(250, 1000, 1),
			mk_row(0, 1000, 1, 1, 0, ST_OK),
			mk_row(-400, 1000, 1),
			mk_row(800, 1000, 1),
			mk_row(800, 1, 1),
			mk_row(-400, 1, 1),
			mk_row(-400, 1023, 1),
			mk_row(1023, 1023, 1),
			mk_row(-1024, 1, 1, 1, -1000, ST_OK),
			mk_row(-1024, 1023, 1),
			mk_row(1023, 1, 1),
			mk_row(200, 600, 1),
			mk_row(-100, 300, 1),
			mk_row(350, 900, 1),
			mk_row(1023, 1023, 0, 1, 0, ST_READ_FAIL),
			mk_row(-1, 512, 1)
		};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (table_rows[i])
			send_reading(table_rows[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			case ($urandom_range(0, 9))
				0: row = mk_row($urandom_range(0, 2047), $urandom_range(0, 1023),
					$urandom_range(0, 1));
				1: row = mk_row($urandom_range(0, 2047), $urandom_range(0, 1023), 0);
				2: row = mk_row($urandom_range(0, 1200) - 400, 0, 1);
				default: row = mk_row($urandom_range(0, 1200) - 400,
					$urandom_range(1, 1000), 1);
			endcase
			send_reading(row);
		end
		reading.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int gap;
		result.ready = 1'b0;
		@(posedge arst_n);
		repeat (300) @(negedge clk);
		repeat (400) @(negedge clk);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
				result.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// checker
	always @(posedge clk) begin
		dew_result_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				exp_r = expected_q.pop_front();
				if (result.dew_point !== exp_r.dew_point)
					report_mismatch($sformatf("dew_point %0d expected %0d",
						result.dew_point, exp_r.dew_point));
				if (result.status !== exp_r.status)
					report_mismatch($sformatf("status %0d expected %0d",
						result.status, exp_r.status));
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((reading.valid && reading.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done);
		fork
			begin
				wait (expected_q.size() == 0);
				repeat (LATENCY + 10) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WATCHDOG_LIMIT);
				err_count++;
			end
		join_any
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		if (!stim_done) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule
